// File: sv/tlf_pkg.sv
package tlf_pkg;

	localparam int WINDOW_W = 32;
	localparam int WINDOW_H = 24;

	localparam int TILE_W  = 10;
	localparam int MAP_W   = 11;
	localparam int POS_W   = 22;
	localparam int RAD_W   = 18;
	localparam int STR_W   = 16;
	localparam int COL_W   = 12;
	localparam int OUT_W   = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd3;

	localparam logic [MAP_W-1:0] MAP_DIM_RST = 11'd1024;

	// working widths with 8 fraction bits (10.8 offsets, 20.8 squares)
	localparam int DPOS_W = 18;
	localparam int SQ_W   = 28;
	localparam int DIST_W = 29;
	localparam int RADS_W = 14;
	localparam int RAD2_W = 20;
	localparam int STRS_W = 12;
	localparam int NUM_W  = 32;
	localparam int DEN_W  = 24;
	localparam int REM_W  = 24;

	// quotient never exceeds strength >> 4
	localparam int QUO_W          = 12;
	localparam int DIV_BITS_STAGE = 2;
	localparam int DIV_STAGES     = QUO_W / DIV_BITS_STAGE;

	typedef struct packed {
		logic             vis;
		logic             lit;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} side_t;

endpackage

// File: sv/tlf_div.sv
module tlf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tlf_pkg::NUM_W-1:0]   num,
	input  logic [tlf_pkg::DEN_W-1:0]   den,
	input  tlf_pkg::side_t              side_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tlf_pkg::QUO_W-1:0]   quo,
	output tlf_pkg::side_t              side_out
);
	import tlf_pkg::*;

	logic [DIV_STAGES-1:0] v_s;
	logic [DIV_STAGES-1:0] en_s;
	logic [REM_W-1:0]      rem_s  [DIV_STAGES];
	logic [QUO_W-1:0]      low_s  [DIV_STAGES];
	logic [QUO_W-1:0]      quo_s  [DIV_STAGES];
	logic [DEN_W-1:0]      den_s  [DIV_STAGES];
	side_t                 side_s [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			logic             v_p;
			logic [REM_W-1:0] rem_p;
			logic [QUO_W-1:0] low_p;
			logic [QUO_W-1:0] quo_p;
			logic [DEN_W-1:0] den_p;
			side_t            side_p;
			logic [REM_W-1:0] rem_n;
			logic [QUO_W-1:0] low_n;
			logic [QUO_W-1:0] quo_n;
			logic             dn_rdy;

			if (k == 0) begin : g_first
				assign v_p    = in_valid;
				assign rem_p  = REM_W'(num[NUM_W-1:QUO_W]);
				assign low_p  = num[QUO_W-1:0];
				assign quo_p  = '0;
				assign den_p  = den;
				assign side_p = side_in;
			end else begin : g_next
				assign v_p    = v_s[k-1];
				assign rem_p  = rem_s[k-1];
				assign low_p  = low_s[k-1];
				assign quo_p  = quo_s[k-1];
				assign den_p  = den_s[k-1];
				assign side_p = side_s[k-1];
			end

			if (k == DIV_STAGES - 1) begin : g_last
				assign dn_rdy = out_ready;
			end else begin : g_mid
				assign dn_rdy = en_s[k+1];
			end

			assign en_s[k] = ~v_s[k] | dn_rdy;

			// restoring steps, one quotient bit each
			always_comb begin
				logic [REM_W:0] t;
				rem_n = rem_p;
				low_n = low_p;
				quo_n = quo_p;
				for (int j = 0; j < DIV_BITS_STAGE; j++) begin
					t     = {rem_n, low_n[QUO_W-1]};
					low_n = {low_n[QUO_W-2:0], 1'b0};
					if (t >= {1'b0, den_p}) begin
						rem_n = REM_W'(t - {1'b0, den_p});
						quo_n = {quo_n[QUO_W-2:0], 1'b1};
					end else begin
						rem_n = t[REM_W-1:0];
						quo_n = {quo_n[QUO_W-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en_s[k]) begin
					v_s[k] <= v_p;
				end
			end

			always_ff @(posedge clk) begin
				if (en_s[k] && v_p) begin
					rem_s[k]  <= rem_n;
					low_s[k]  <= low_n;
					quo_s[k]  <= quo_n;
					den_s[k]  <= den_p;
					side_s[k] <= side_p;
				end
			end
		end
	endgenerate

	assign in_ready  = en_s[0];
	assign out_valid = v_s[DIV_STAGES-1];
	assign quo       = quo_s[DIV_STAGES-1];
	assign side_out  = side_s[DIV_STAGES-1];

endmodule

// File: sv/tile_light_falloff_top.sv
// Point-light falloff for one map tile per transaction. A tile outside the map or the
// WINDOW_W x WINDOW_H window gets all-zero results; a visible tile within the light radius
// gets rad2*(strength>>4)/(rad2+9*dist2) << 4 and the colour scaled by it. Fully pipelined:
// one transaction per cycle unless the output stalls, through four arithmetic stages, six stages
// of a two-bit-per-stage restoring divider and one colour-multiply stage. Stalls propagate stage
// by stage, so bubbles close up while the output is held. Configuration writes are always
// accepted and must only be issued while the pipeline is empty.
module tile_light_falloff_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tlf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tlf_pkg::TILE_W-1:0]        tile_x,
	input  logic [tlf_pkg::TILE_W-1:0]        tile_y,
	input  logic [tlf_pkg::POS_W-1:0]         light_x,
	input  logic [tlf_pkg::POS_W-1:0]         light_y,
	input  logic [tlf_pkg::RAD_W-1:0]         light_radius,
	input  logic [tlf_pkg::STR_W-1:0]         light_strength,
	input  logic [tlf_pkg::COL_W-1:0]         red_in,
	input  logic [tlf_pkg::COL_W-1:0]         green_in,
	input  logic [tlf_pkg::COL_W-1:0]         blue_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              visible,
	output logic                              lit,
	output logic [tlf_pkg::OUT_W-1:0]         light_level,
	output logic [tlf_pkg::OUT_W-1:0]         red_out,
	output logic [tlf_pkg::OUT_W-1:0]         green_out,
	output logic [tlf_pkg::OUT_W-1:0]         blue_out
);
	import tlf_pkg::*;

	localparam logic [MAP_W-1:0] WIN_W = MAP_W'(WINDOW_W);
	localparam logic [MAP_W-1:0] WIN_H = MAP_W'(WINDOW_H);

	logic [TILE_W-1:0] window_x_q;
	logic [TILE_W-1:0] window_y_q;
	logic [MAP_W-1:0]  map_width_q;
	logic [MAP_W-1:0]  map_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_x_q   <= '0;
			window_y_q   <= '0;
			map_width_q  <= MAP_DIM_RST;
			map_height_q <= MAP_DIM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WINDOW_X:   window_x_q   <= cfg_data[TILE_W-1:0];
				CFG_WINDOW_Y:   window_y_q   <= cfg_data[TILE_W-1:0];
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables
	logic en_s1, en_s2, en_s3, en_s4, en_s11;
	logic v_s1, v_s2, v_s3, v_s4, v_s11;
	logic div_in_ready, div_out_valid;

	assign en_s4  = ~v_s4 | div_in_ready;
	assign en_s3  = ~v_s3 | en_s4;
	assign en_s2  = ~v_s2 | en_s3;
	assign en_s1  = ~v_s1 | en_s2;
	assign en_s11 = ~v_s11 | out_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= in_valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s11) v_s11 <= div_out_valid;
		end
	end

	// stage 1: visibility, distance magnitudes
	logic [MAP_W-1:0]  tx_ext, ty_ext;
	logic              vis_c;
	logic [DPOS_W-1:0] lx4, ly4, tx8, ty8, mx_c, my_c;

	assign tx_ext = {1'b0, tile_x};
	assign ty_ext = {1'b0, tile_y};
	assign vis_c  = (tx_ext < map_width_q) && (ty_ext < map_height_q) &&
	                (tile_x >= window_x_q) && (tx_ext < ({1'b0, window_x_q} + WIN_W)) &&
	                (tile_y >= window_y_q) && (ty_ext < ({1'b0, window_y_q} + WIN_H));
	assign lx4  = light_x[POS_W-1:4];
	assign ly4  = light_y[POS_W-1:4];
	assign tx8  = {tile_x, 8'd0};
	assign ty8  = {tile_y, 8'd0};
	assign mx_c = (lx4 >= tx8) ? (lx4 - tx8) : (tx8 - lx4);
	assign my_c = (ly4 >= ty8) ? (ly4 - ty8) : (ty8 - ly4);

	logic              vis_s1;
	logic [DPOS_W-1:0] mx_s1, my_s1;
	logic [RADS_W-1:0] rad_s1;
	logic [STRS_W-1:0] str_s1;
	logic [COL_W-1:0]  red_s1, green_s1, blue_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			vis_s1   <= vis_c;
			mx_s1    <= mx_c;
			my_s1    <= my_c;
			rad_s1   <= light_radius[RAD_W-1:4];
			str_s1   <= light_strength[STR_W-1:4];
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
		end
	end

	// stage 2: squares
	logic [2*DPOS_W-1:0] mx2, my2;
	logic [2*RADS_W-1:0] rr;

	assign mx2 = mx_s1 * mx_s1;
	assign my2 = my_s1 * my_s1;
	assign rr  = rad_s1 * rad_s1;

	logic              vis_s2;
	logic [SQ_W-1:0]   dx2_s2, dy2_s2;
	logic [RAD2_W-1:0] rad2_s2;
	logic [STRS_W-1:0] str_s2;
	logic [COL_W-1:0]  red_s2, green_s2, blue_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			vis_s2   <= vis_s1;
			dx2_s2   <= mx2[2*DPOS_W-1:8];
			dy2_s2   <= my2[2*DPOS_W-1:8];
			rad2_s2  <= rr[2*RADS_W-1:8];
			str_s2   <= str_s1;
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
		end
	end

	// stage 3: reach test, numerator
	logic [DIST_W-1:0] dist2_c;
	assign dist2_c = DIST_W'(dx2_s2) + DIST_W'(dy2_s2);

	logic              vis_s3, lit_s3;
	logic [RAD2_W-1:0] dist2_s3, rad2_s3;
	logic [NUM_W-1:0]  num_s3;
	logic [COL_W-1:0]  red_s3, green_s3, blue_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			vis_s3   <= vis_s2;
			lit_s3   <= vis_s2 && (dist2_c < DIST_W'(rad2_s2));
			dist2_s3 <= dist2_c[RAD2_W-1:0];
			rad2_s3  <= rad2_s2;
			num_s3   <= rad2_s2 * str_s2;
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
		end
	end

	// stage 4: denominator
	logic [DEN_W-1:0] den_c;
	assign den_c = DEN_W'(rad2_s3) + DEN_W'({dist2_s3, 3'd0}) + DEN_W'(dist2_s3);

	logic [DEN_W-1:0] den_s4;
	logic [NUM_W-1:0] num_s4;
	side_t            side_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			den_s4        <= den_c;
			num_s4        <= num_s3;
			side_s4.vis   <= vis_s3;
			side_s4.lit   <= lit_s3;
			side_s4.red   <= red_s3;
			side_s4.green <= green_s3;
			side_s4.blue  <= blue_s3;
		end
	end

	logic [QUO_W-1:0] div_quo;
	side_t            div_side;

	tlf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.num       (num_s4),
		.den       (den_s4),
		.side_in   (side_s4),
		.out_valid (div_out_valid),
		.out_ready (en_s11),
		.quo       (div_quo),
		.side_out  (div_side)
	);

	// output stage: level and colour scaling
	logic [OUT_W-1:0]       level_c;
	logic [COL_W+OUT_W-1:0] rp, gp, bp;

	assign level_c = div_side.lit ? {div_quo, 4'd0} : '0;
	assign rp      = div_side.red   * level_c;
	assign gp      = div_side.green * level_c;
	assign bp      = div_side.blue  * level_c;

	logic             vis_s11, lit_s11;
	logic [OUT_W-1:0] level_s11, red_s11, green_s11, blue_s11;

	always_ff @(posedge clk) begin
		if (en_s11 && div_out_valid) begin
			vis_s11   <= div_side.vis;
			lit_s11   <= div_side.lit;
			level_s11 <= level_c;
			red_s11   <= rp[COL_W+OUT_W-1:COL_W];
			green_s11 <= gp[COL_W+OUT_W-1:COL_W];
			blue_s11  <= bp[COL_W+OUT_W-1:COL_W];
		end
	end

	assign out_valid   = v_s11;
	assign visible     = vis_s11;
	assign lit         = lit_s11;
	assign light_level = level_s11;
	assign red_out     = red_s11;
	assign green_out   = green_s11;
	assign blue_out    = blue_s11;

endmodule

// File: sv/tlf_checker.sv
module tlf_assert (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              visible,
	input logic                              lit,
	input logic [tlf_pkg::OUT_W-1:0]         light_level,
	input logic [tlf_pkg::OUT_W-1:0]         red_out,
	input logic [tlf_pkg::OUT_W-1:0]         green_out,
	input logic [tlf_pkg::OUT_W-1:0]         blue_out
);

	// held transaction keeps its result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(light_level) && $stable(lit) &&
		$stable(visible) && $stable(red_out) && $stable(green_out) && $stable(blue_out))
		else $error("result changed while stalled");

	a_lit_vis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lit |-> visible)
		else $error("lit tile not visible");

	a_unlit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lit |-> light_level == '0 && red_out == '0 &&
		green_out == '0 && blue_out == '0)
		else $error("unlit tile carries light");

	a_level_grain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> light_level[3:0] == 4'd0)
		else $error("light level not a multiple of 16");

	// colour below full scale never exceeds the level
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red_out <= light_level && green_out <= light_level &&
		blue_out <= light_level)
		else $error("colour above light level");

endmodule

bind tile_light_falloff_top tlf_assert u_tlf_assert (.*);
